>>> rtl/invert_matrix_3x3_defines.svh
// Assertion macros used by the checker of the block.
`ifndef INVERT_MATRIX_3X3_DEFINES_SVH
`define INVERT_MATRIX_3X3_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define IMX_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("invert_matrix_3x3 check failed");

// Condition checked at every clock edge outside reset.
`define IMX_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invert_matrix_3x3 check failed");

`endif

>>> rtl/imx_pkg.sv
package imx_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// register stages besides the one-bit-per-stage divider steps
	localparam int FIXED_STAGES = 9;

	// operand pairs of the adjugate: adj[k] = a[PA]*a[PB] - a[NA]*a[NB]
	localparam logic [3:0] ADJ_PA [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
	localparam logic [3:0] ADJ_PB [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
	localparam logic [3:0] ADJ_NA [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
	localparam logic [3:0] ADJ_NB [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

	typedef struct packed {
		logic valid;
		logic singular;
	} imx_ctrl_t;

endpackage

>>> rtl/invert_matrix_3x3.sv
// 3x3 matrix inverse by the adjugate, signed fixed point. One item enters per
// clock whenever start is high; busy stays low, so every cycle can take an
// item. Each result shows on the out ports for one cycle with done high,
// exactly ELEM_WIDTH+10 cycles after its item was taken (42 at the default
// width), and the receiver must take it then. The latency is set by the
// divider, which resolves one quotient bit per pipeline stage for each of the
// nine elements. Quotients are rounded to nearest, ties away from zero, and
// saturated; a zero determinant raises singular with all elements zero.
module invert_matrix_3x3 #(
	parameter int ELEM_WIDTH = imx_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = imx_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
	input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
	input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
	input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
	input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
	output logic                         done,
	output logic signed [ELEM_WIDTH-1:0] out_r0c0,
	output logic signed [ELEM_WIDTH-1:0] out_r0c1,
	output logic signed [ELEM_WIDTH-1:0] out_r0c2,
	output logic signed [ELEM_WIDTH-1:0] out_r1c0,
	output logic signed [ELEM_WIDTH-1:0] out_r1c1,
	output logic signed [ELEM_WIDTH-1:0] out_r1c2,
	output logic signed [ELEM_WIDTH-1:0] out_r2c0,
	output logic signed [ELEM_WIDTH-1:0] out_r2c1,
	output logic signed [ELEM_WIDTH-1:0] out_r2c2,
	output logic                         singular
);

	logic signed [ELEM_WIDTH-1:0]   mat [9];
	logic signed [ELEM_WIDTH-1:0]   inv [9];
	logic                           valid_s2;
	logic signed [ELEM_WIDTH-1:0]   a_s2 [9];
	logic signed [2*ELEM_WIDTH:0]   adj_s2 [9];
	logic signed [2*ELEM_WIDTH:0]   adj_s5 [9];
	logic signed [3*ELEM_WIDTH:0]   det_s5;
	imx_pkg::imx_ctrl_t             ctrl_s5;

	assign busy = 1'b0;

	assign mat[0] = in_r0c0;
	assign mat[1] = in_r0c1;
	assign mat[2] = in_r0c2;
	assign mat[3] = in_r1c0;
	assign mat[4] = in_r1c1;
	assign mat[5] = in_r1c2;
	assign mat[6] = in_r2c0;
	assign mat[7] = in_r2c1;
	assign mat[8] = in_r2c2;

	imx_cofactor #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_cofactor (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start && !busy),
		.a       (mat),
		.valid_s2(valid_s2),
		.a_s2    (a_s2),
		.adj_s2  (adj_s2)
	);

	imx_det #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s2(valid_s2),
		.a_s2    (a_s2),
		.adj_s2  (adj_s2),
		.ctrl_s5 (ctrl_s5),
		.adj_s5  (adj_s5),
		.det_s5  (det_s5)
	);

	imx_div #(
		.ELEM_WIDTH(ELEM_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s5 (ctrl_s5),
		.adj_s5  (adj_s5),
		.det_s5  (det_s5),
		.done    (done),
		.singular(singular),
		.quot    (inv)
	);

	assign out_r0c0 = inv[0];
	assign out_r0c1 = inv[1];
	assign out_r0c2 = inv[2];
	assign out_r1c0 = inv[3];
	assign out_r1c1 = inv[4];
	assign out_r1c2 = inv[5];
	assign out_r2c0 = inv[6];
	assign out_r2c1 = inv[7];
	assign out_r2c2 = inv[8];

endmodule

>>> rtl/imx_cofactor.sv
module imx_cofactor #(
	parameter int ELEM_WIDTH = imx_pkg::ELEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [ELEM_WIDTH-1:0] a [9],
	output logic                         valid_s2,
	output logic signed [ELEM_WIDTH-1:0] a_s2 [9],
	output logic signed [2*ELEM_WIDTH:0] adj_s2 [9]
);

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int AW = PW + 1;

	logic                         valid_s1;
	logic signed [ELEM_WIDTH-1:0] a_s1 [9];
	logic signed [PW-1:0]         pos_s1 [9];
	logic signed [PW-1:0]         neg_s1 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			a_s1[k]   <= a[k];
			pos_s1[k] <= a[imx_pkg::ADJ_PA[k]] * a[imx_pkg::ADJ_PB[k]];
			neg_s1[k] <= a[imx_pkg::ADJ_NA[k]] * a[imx_pkg::ADJ_NB[k]];
			a_s2[k]   <= a_s1[k];
			adj_s2[k] <= AW'(pos_s1[k]) - AW'(neg_s1[k]);
		end
	end

endmodule

>>> rtl/imx_det.sv
module imx_det #(
	parameter int ELEM_WIDTH = imx_pkg::ELEM_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s2,
	input  logic signed [ELEM_WIDTH-1:0]   a_s2 [9],
	input  logic signed [2*ELEM_WIDTH:0]   adj_s2 [9],
	output imx_pkg::imx_ctrl_t             ctrl_s5,
	output logic signed [2*ELEM_WIDTH:0]   adj_s5 [9],
	output logic signed [3*ELEM_WIDTH:0]   det_s5
);

	localparam int AW = 2 * ELEM_WIDTH + 1;
	localparam int DW = 3 * ELEM_WIDTH + 1;

	logic                   valid_s3;
	logic                   valid_s4;
	logic signed [AW-1:0]   adj_s3 [9];
	logic signed [AW-1:0]   adj_s4 [9];
	logic signed [AW-1:0]   plo_s3 [3];
	logic signed [AW-1:0]   phi_s3 [3];
	logic signed [DW-1:0]   term_s4 [3];
	logic signed [DW-1:0]   det_sum;

	assign det_sum = term_s4[0] + term_s4[1] + term_s4[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			ctrl_s5  <= '0;
		end else begin
			valid_s3         <= valid_s2;
			valid_s4         <= valid_s3;
			ctrl_s5.valid    <= valid_s4;
			ctrl_s5.singular <= valid_s4 && (det_sum == '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			adj_s3[k] <= adj_s2[k];
			adj_s4[k] <= adj_s3[k];
			adj_s5[k] <= adj_s4[k];
		end
		for (int j = 0; j < 3; j++) begin
			plo_s3[j]  <= a_s2[3*j] * $signed({1'b0, adj_s2[j][ELEM_WIDTH-1:0]});
			phi_s3[j]  <= a_s2[3*j] * $signed(adj_s2[j][AW-1:ELEM_WIDTH]);
			term_s4[j] <= DW'(plo_s3[j]) + (DW'(phi_s3[j]) <<< ELEM_WIDTH);
		end
		det_s5 <= det_sum;
	end

endmodule

>>> rtl/imx_div_step.sv
module imx_div_step #(
	parameter int DEN_W = 3 * imx_pkg::ELEM_WIDTH_DEF + 1,
	parameter int QW    = imx_pkg::ELEM_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic [DEN_W-1:0] den,
	input  logic [DEN_W-1:0] rem,
	input  logic [QW-1:0]    low,
	input  logic [QW-1:0]    quo,
	output logic [DEN_W-1:0] rem_sn,
	output logic [QW-1:0]    low_sn,
	output logic [QW-1:0]    quo_sn
);

	logic [DEN_W:0] cand;
	logic [DEN_W:0] diff;
	logic           ge;

	assign cand = {rem, low[QW-1]};
	assign diff = cand - {1'b0, den};
	assign ge   = cand >= {1'b0, den};

	always_ff @(posedge clk) begin
		rem_sn <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
		low_sn <= {low[QW-2:0], 1'b0};
		quo_sn <= {quo[QW-2:0], ge};
	end

endmodule

>>> rtl/imx_div.sv
module imx_div #(
	parameter int ELEM_WIDTH = imx_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = imx_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  imx_pkg::imx_ctrl_t           ctrl_s5,
	input  logic signed [2*ELEM_WIDTH:0] adj_s5 [9],
	input  logic signed [3*ELEM_WIDTH:0] det_s5,
	output logic                         done,
	output logic                         singular,
	output logic signed [ELEM_WIDTH-1:0] quot [9]
);

	localparam int AW    = 2 * ELEM_WIDTH + 1;
	localparam int DW    = 3 * ELEM_WIDTH + 1;
	localparam int NMW   = 2 * ELEM_WIDTH;
	localparam int MW    = 3 * ELEM_WIDTH;
	localparam int DEN_W = MW + 1;
	localparam int SHW   = 2 * ELEM_WIDTH + 2 * FRAC_BITS + 1;
	localparam int NUM_W = ((SHW > MW) ? SHW : MW) + 1;
	localparam int QW    = ELEM_WIDTH + 1;
	localparam logic [QW-1:0]         LIM  = {2'b01, {(ELEM_WIDTH-1){1'b0}}};
	localparam logic [ELEM_WIDTH-1:0] MAXV = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
	localparam logic [ELEM_WIDTH-1:0] MINV = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

	imx_pkg::imx_ctrl_t ctrl_s6, ctrl_s7;
	logic [NMW-1:0]   adjm_s6 [9];
	logic [8:0]       neg_s6, neg_s7;
	logic [MW-1:0]    detm_s6;
	logic [NUM_W-1:0] num_s7 [9];
	logic [DEN_W-1:0] den_s7;

	imx_pkg::imx_ctrl_t ctrl_sd [QW+1];
	logic [DEN_W-1:0] den_sd [QW+1];
	logic [8:0]       ovf_sd [QW+1];
	logic [8:0]       neg_sd [QW+1];
	logic [DEN_W-1:0] rem_sd [QW+1][9];
	logic [QW-1:0]    low_sd [QW+1][9];
	logic [QW-1:0]    quo_sd [QW+1][9];

	logic [ELEM_WIDTH-1:0] res [9];
	logic [QW-1:0]         qneg [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
			for (int i = 0; i <= QW; i++) begin
				ctrl_sd[i] <= '0;
			end
			done     <= 1'b0;
			singular <= 1'b0;
		end else begin
			ctrl_s6    <= ctrl_s5;
			ctrl_s7    <= ctrl_s6;
			ctrl_sd[0] <= ctrl_s7;
			for (int i = 1; i <= QW; i++) begin
				ctrl_sd[i] <= ctrl_sd[i-1];
			end
			done     <= ctrl_sd[QW].valid;
			singular <= ctrl_sd[QW].valid && ctrl_sd[QW].singular;
		end
	end

	always_ff @(posedge clk) begin
		detm_s6 <= MW'(det_s5[DW-1] ? -det_s5 : det_s5);
		den_s7  <= {detm_s6, 1'b0};
		neg_s7  <= neg_s6;
		den_sd[0] <= den_s7;
		neg_sd[0] <= neg_s7;
		for (int k = 0; k < 9; k++) begin
			adjm_s6[k] <= NMW'(adj_s5[k][AW-1] ? -adj_s5[k] : adj_s5[k]);
			neg_s6[k]  <= adj_s5[k][AW-1] ^ det_s5[DW-1];
			num_s7[k]  <= (NUM_W'(adjm_s6[k]) << (2 * FRAC_BITS + 1)) + NUM_W'(detm_s6);
			ovf_sd[0][k] <= (num_s7[k] >> QW) >= NUM_W'(den_s7);
			rem_sd[0][k] <= DEN_W'(num_s7[k] >> QW);
			low_sd[0][k] <= num_s7[k][QW-1:0];
			quo_sd[0][k] <= '0;
		end
		for (int i = 1; i <= QW; i++) begin
			den_sd[i] <= den_sd[i-1];
			ovf_sd[i] <= ovf_sd[i-1];
			neg_sd[i] <= neg_sd[i-1];
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		for (genvar k = 0; k < 9; k++) begin : g_lane
			imx_div_step #(
				.DEN_W(DEN_W),
				.QW   (QW)
			) u_step (
				.clk   (clk),
				.den   (den_sd[i]),
				.rem   (rem_sd[i][k]),
				.low   (low_sd[i][k]),
				.quo   (quo_sd[i][k]),
				.rem_sn(rem_sd[i+1][k]),
				.low_sn(low_sd[i+1][k]),
				.quo_sn(quo_sd[i+1][k])
			);
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			qneg[k] = ~quo_sd[QW][k] + QW'(1);
			if (ctrl_sd[QW].singular) begin
				res[k] = '0;
			end else if (!neg_sd[QW][k] && (ovf_sd[QW][k] || quo_sd[QW][k] >= LIM)) begin
				res[k] = MAXV;
			end else if (neg_sd[QW][k] && (ovf_sd[QW][k] || quo_sd[QW][k] > LIM)) begin
				res[k] = MINV;
			end else if (neg_sd[QW][k]) begin
				res[k] = qneg[k][ELEM_WIDTH-1:0];
			end else begin
				res[k] = quo_sd[QW][k][ELEM_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			quot[k] <= $signed(res[k]);
		end
	end

endmodule

>>> rtl/imx_checker.sv
`include "invert_matrix_3x3_defines.svh"

module imx_checker #(
	parameter int ELEM_WIDTH = imx_pkg::ELEM_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [ELEM_WIDTH-1:0] in_r0c0,
	input logic signed [ELEM_WIDTH-1:0] in_r0c1,
	input logic signed [ELEM_WIDTH-1:0] in_r0c2,
	input logic                         done,
	input logic signed [ELEM_WIDTH-1:0] out_r0c0,
	input logic signed [ELEM_WIDTH-1:0] out_r0c1,
	input logic signed [ELEM_WIDTH-1:0] out_r0c2,
	input logic signed [ELEM_WIDTH-1:0] out_r1c0,
	input logic signed [ELEM_WIDTH-1:0] out_r1c1,
	input logic signed [ELEM_WIDTH-1:0] out_r1c2,
	input logic signed [ELEM_WIDTH-1:0] out_r2c0,
	input logic signed [ELEM_WIDTH-1:0] out_r2c1,
	input logic signed [ELEM_WIDTH-1:0] out_r2c2,
	input logic                         singular
);

	localparam int LAT = imx_pkg::FIXED_STAGES + ELEM_WIDTH + 1;

	logic out_zero;
	logic row0_zero;

	assign out_zero = out_r0c0 == '0 && out_r0c1 == '0 && out_r0c2 == '0
		&& out_r1c0 == '0 && out_r1c1 == '0 && out_r1c2 == '0
		&& out_r2c0 == '0 && out_r2c1 == '0 && out_r2c2 == '0;
	assign row0_zero = in_r0c0 == '0 && in_r0c1 == '0 && in_r0c2 == '0;

	`IMX_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy, LAT))
	`IMX_ASSERT_ALWAYS(a_singular_with_done, !singular || done)
	`IMX_ASSERT_IMPL(a_singular_zero_out, done && singular, out_zero)
	`IMX_ASSERT_IMPL(a_zero_row_singular, done && $past(row0_zero, LAT), singular)

endmodule

bind invert_matrix_3x3 imx_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_imx_checker (.*);
